[rtl/piaw_pkg.sv]
// package for the packed integer array: sizes, codes, request and response types
package piaw_pkg;

  localparam int unsigned StoreWords = 64;
  localparam int unsigned WordBits   = 64;
  localparam int unsigned MaxEntries = 4096;
  localparam int unsigned AddrBits   = $clog2(StoreWords);
  localparam int unsigned StoreBits  = StoreWords * WordBits;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_UNUSED    = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] value_in;
    logic [11:0] index;
  } req_t;

  typedef struct packed {
    logic [63:0] read_value;
    logic [12:0] entry_count;
    logic [6:0]  entry_width;
    logic [1:0]  status;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_RD0,
    S_RD1,
    S_RDW,
    S_FWR0,
    S_FWR1,
    S_FWR1W,
    S_FWR2,
    S_FWRW,
    S_OUT
  } state_e;

  // mask of the low w bits
  function automatic logic [63:0] width_mask(input logic [6:0] w);
    logic [63:0] m;
    if (w >= 7'd64) m = '1;
    else m = (64'd1 << w[5:0]) - 64'd1;
    return m;
  endfunction

endpackage

[rtl/packed_int_array_autowidth.sv]
// top level of the packed integer array
// rejected, zero-width and unused requests go straight to the response; a read fetches
// its entry; an append does a read-modify-write of its word, and of both words when the
// entry straddles two; an append that widens entries first walks every stored entry
// clear sweeps the 64 store words, one per cycle; one request at a time, the next taken
// in the cycle after the response; async active low reset runs a clear sweep
module packed_int_array_autowidth (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  piaw_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output piaw_pkg::rsp_t out_data_o
);

  logic                          we;
  logic [piaw_pkg::AddrBits-1:0] addr;
  logic [63:0]                   wdata, rdata;

  // sequencer
  piaw_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .req_valid_i(in_valid_i), .req_ready_o(in_ready_o), .req_i(in_data_i),
    .rsp_valid_o(out_valid_o), .rsp_ready_i(out_ready_i), .rsp_o(out_data_o),
    .we_o(we), .addr_o(addr), .wdata_o(wdata), .rdata_i(rdata)
  );

  // word store
  piaw_ram #(.Width(piaw_pkg::WordBits), .Depth(piaw_pkg::StoreWords)) u_store (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

endmodule

[rtl/piaw_ram.sv]
// generic single port ram with registered read
module piaw_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end

endmodule

[rtl/piaw_ctrl.sv]
// sequencer: clear sweep, entry fetch and place with read-modify-write, repack walk
module piaw_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  piaw_pkg::req_t                req_i,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output piaw_pkg::rsp_t                rsp_o,
  output logic                          we_o,
  output logic [piaw_pkg::AddrBits-1:0] addr_o,
  output logic [63:0]                   wdata_o,
  input  logic [63:0]                   rdata_i
);

  localparam int unsigned AB = piaw_pkg::AddrBits;

  piaw_pkg::state_e state_q, state_d;
  logic [12:0] count_q, count_d;
  logic [6:0]  width_q, width_d;
  // operation in flight
  logic        rd_mode_q, rd_mode_d;     // read request (else placing)
  logic        repack_q, repack_d;       // walking entries
  logic        clr_rsp_q, clr_rsp_d;     // sweep answers a clear request (not the reset sweep)
  logic [6:0]  new_w_q, new_w_d;
  logic [12:0] pos_q, pos_d;             // entry being moved
  logic [63:0] val_q, val_d;
  logic [63:0] app_q, app_d;             // value appended once the walk ends
  logic [63:0] lo_q, lo_d;
  logic [AB-1:0] cnt_q, cnt_d;           // clear sweep address
  piaw_pkg::rsp_t rsp_q, rsp_d;
  logic [AB-1:0] word_q, word_d;
  logic [5:0]  off_q, off_d;
  logic [6:0]  pw_q, pw_d;               // width of the current access

  // bit position of an entry at a width
  logic [19:0] bitpos;
  logic [6:0]  bl;
  logic [6:0]  w_need;
  logic [19:0] need_bits;
  logic        straddle;
  logic [6:0]  hi_sh;
  logic [63:0] m, vm;
  logic [63:0] fetched;

  // bit length of the value to append
  always_comb begin
    bl = 7'd0;
    for (int k = 0; k < 64; k++) if (req_i.value_in[k]) bl = 7'(k + 1);
  end

  assign w_need    = (bl > width_q) ? bl : width_q;
  assign need_bits = {7'd0, count_q + 13'd1} * {13'd0, w_need};
  assign m         = piaw_pkg::width_mask(pw_q);
  assign vm        = val_q & m;
  assign straddle  = ({1'b0, off_q} + pw_q) > 7'd64;
  assign hi_sh     = 7'd64 - {1'b0, off_q};
  assign fetched   = straddle ? ((lo_q | (rdata_i << hi_sh)) & m) : lo_q;

  assign req_ready_o = (state_q == piaw_pkg::S_IDLE);
  assign rsp_valid_o = (state_q == piaw_pkg::S_OUT);

  // count and width are steady while the response waits
  always_comb begin
    rsp_o = rsp_q;
    rsp_o.entry_count = count_q;
    rsp_o.entry_width = width_q;
  end

  always_comb begin
    state_d = state_q; count_d = count_q; width_d = width_q;
    rd_mode_d = rd_mode_q; repack_d = repack_q; clr_rsp_d = clr_rsp_q;
    new_w_d = new_w_q; pos_d = pos_q; val_d = val_q; app_d = app_q; lo_d = lo_q;
    cnt_d = cnt_q; rsp_d = rsp_q; word_d = word_q; off_d = off_q; pw_d = pw_q;
    we_o = 1'b0; addr_o = word_q; wdata_o = '0;
    bitpos = '0;
    case (state_q)
      piaw_pkg::S_IDLE: begin
        if (req_valid_i) begin
          rsp_d = '0;
          case (piaw_pkg::cmd_e'(req_i.command))
            piaw_pkg::CMD_APPEND: begin
              if (count_q >= 13'(piaw_pkg::MaxEntries) ||
                  need_bits > 20'(piaw_pkg::StoreBits)) begin
                rsp_d.status = piaw_pkg::ST_FULL;
                state_d = piaw_pkg::S_OUT;
              end else if (w_need > width_q && count_q != 13'd0 && width_q != 7'd0) begin
                // repack walk from the last entry down
                repack_d = 1'b1; rd_mode_d = 1'b0; new_w_d = w_need;
                app_d = req_i.value_in; pos_d = count_q - 13'd1;
                bitpos = {7'd0, count_q - 13'd1} * {13'd0, width_q};
                word_d = bitpos[AB+5:6]; off_d = bitpos[5:0]; pw_d = width_q;
                state_d = piaw_pkg::S_RD0;
              end else begin
                repack_d = 1'b0; rd_mode_d = 1'b0;
                width_d = w_need; val_d = req_i.value_in; pos_d = count_q;
                // entries already zero when width was 0
                bitpos = {7'd0, count_q} * {13'd0, w_need};
                word_d = bitpos[AB+5:6]; off_d = bitpos[5:0]; pw_d = w_need;
                count_d = count_q + 13'd1;
                state_d = (w_need == 7'd0) ? piaw_pkg::S_OUT : piaw_pkg::S_FWR0;
              end
            end
            piaw_pkg::CMD_READ: begin
              if ({1'b0, req_i.index} >= count_q) begin
                rsp_d.status = piaw_pkg::ST_BAD_INDEX;
                state_d = piaw_pkg::S_OUT;
              end else if (width_q == 7'd0) begin
                state_d = piaw_pkg::S_OUT;
              end else begin
                rd_mode_d = 1'b1; repack_d = 1'b0;
                bitpos = {8'd0, req_i.index} * {13'd0, width_q};
                word_d = bitpos[AB+5:6]; off_d = bitpos[5:0]; pw_d = width_q;
                state_d = piaw_pkg::S_RD0;
              end
            end
            piaw_pkg::CMD_CLEAR: begin
              count_d = '0; width_d = '0; cnt_d = '0; clr_rsp_d = 1'b1;
              state_d = piaw_pkg::S_CLR;
            end
            default: state_d = piaw_pkg::S_OUT;
          endcase
        end
      end
      // zero every word, one per cycle
      piaw_pkg::S_CLR: begin
        we_o = 1'b1; addr_o = cnt_q;
        cnt_d = cnt_q + AB'(1);
        if (cnt_q == AB'(piaw_pkg::StoreWords - 1)) begin
          state_d = clr_rsp_q ? piaw_pkg::S_OUT : piaw_pkg::S_IDLE;
        end
      end
      // fetch: low word
      piaw_pkg::S_RD0: begin
        addr_o = word_q;
        state_d = piaw_pkg::S_RD1;
      end
      piaw_pkg::S_RD1: begin
        if (straddle) begin
          addr_o = word_q + AB'(1);
          lo_d = rdata_i >> off_q;
        end else begin
          lo_d = (rdata_i >> off_q) & m;
        end
        state_d = piaw_pkg::S_RDW;
      end
      piaw_pkg::S_RDW: begin
        if (rd_mode_q) begin
          rsp_d.read_value = fetched;
          state_d = piaw_pkg::S_OUT;
        end else begin
          // place at new width
          val_d = fetched;
          bitpos = {7'd0, pos_q} * {13'd0, new_w_q};
          word_d = bitpos[AB+5:6]; off_d = bitpos[5:0]; pw_d = new_w_q;
          state_d = piaw_pkg::S_FWR0;
        end
      end
      // place: read low word
      piaw_pkg::S_FWR0: begin
        addr_o = word_q;
        state_d = piaw_pkg::S_FWR1;
      end
      piaw_pkg::S_FWR1: begin
        we_o = 1'b1; addr_o = word_q;
        wdata_o = (rdata_i & ~(m << off_q)) | (vm << off_q);
        state_d = straddle ? piaw_pkg::S_FWR1W : piaw_pkg::S_FWRW;
      end
      piaw_pkg::S_FWR1W: begin
        addr_o = word_q + AB'(1);
        state_d = piaw_pkg::S_FWR2;
      end
      piaw_pkg::S_FWR2: begin
        we_o = 1'b1; addr_o = word_q + AB'(1);
        wdata_o = (rdata_i & ~(m >> hi_sh)) | (vm >> hi_sh);
        state_d = piaw_pkg::S_FWRW;
      end
      // next repack step, the append after the walk, or done
      piaw_pkg::S_FWRW: begin
        if (repack_q) begin
          if (pos_q == 13'd0) begin
            repack_d = 1'b0; width_d = new_w_q;
            val_d = app_q; pos_d = count_q;
            bitpos = {7'd0, count_q} * {13'd0, new_w_q};
            word_d = bitpos[AB+5:6]; off_d = bitpos[5:0]; pw_d = new_w_q;
            count_d = count_q + 13'd1;
            state_d = piaw_pkg::S_FWR0;
          end else begin
            pos_d = pos_q - 13'd1;
            bitpos = {7'd0, pos_q - 13'd1} * {13'd0, width_q};
            word_d = bitpos[AB+5:6]; off_d = bitpos[5:0]; pw_d = width_q;
            state_d = piaw_pkg::S_RD0;
          end
        end else begin
          state_d = piaw_pkg::S_OUT;
        end
      end
      piaw_pkg::S_OUT: begin
        if (rsp_ready_i) state_d = piaw_pkg::S_IDLE;
      end
      default: state_d = piaw_pkg::S_IDLE;
    endcase
  end

  // state registers, reset starts the clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= piaw_pkg::S_CLR; count_q <= '0; width_q <= '0;
      rd_mode_q <= 1'b0; repack_q <= 1'b0; clr_rsp_q <= 1'b0; cnt_q <= '0;
      new_w_q <= '0; pos_q <= '0; val_q <= '0; app_q <= '0; lo_q <= '0;
      rsp_q <= '0; word_q <= '0; off_q <= '0; pw_q <= '0;
    end else begin
      state_q <= state_d; count_q <= count_d; width_q <= width_d;
      rd_mode_q <= rd_mode_d; repack_q <= repack_d; clr_rsp_q <= clr_rsp_d; cnt_q <= cnt_d;
      new_w_q <= new_w_d; pos_q <= pos_d; val_q <= val_d; app_q <= app_d; lo_q <= lo_d;
      rsp_q <= rsp_d; word_q <= word_d; off_q <= off_d; pw_q <= pw_d;
    end
  end

endmodule

[rtl/piaw_checker.sv]
// port checker for the packed integer array, bound to the top level
module piaw_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input piaw_pkg::rsp_t out_data_o
);

  // one request at a time
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("accept while busy");

  // response holds while stalled
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("response changed");

  // width never exceeds 64
  a_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.entry_width <= 7'd64) else $error("width");

  // bad index carries zero data
  a_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == piaw_pkg::ST_BAD_INDEX |->
    out_data_o.read_value == '0) else $error("bad index data");

endmodule

bind packed_int_array_autowidth piaw_checker u_checker (.*);

[tb/tb_packed_int_array_autowidth.sv]
// testbench for the packed integer array: directed and random requests against a predictor
`timescale 1ns / 100ps

module tb_packed_int_array_autowidth;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  piaw_pkg::req_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  piaw_pkg::rsp_t out_data_o;

  packed_int_array_autowidth dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // predictor state
  logic [63:0] shadow_words [piaw_pkg::StoreWords];
  int unsigned shadow_count;
  int unsigned shadow_width;

  piaw_pkg::rsp_t expected_rsps[$];
  int unsigned mismatch_count;
  int unsigned requests_sent;
  int unsigned responses_seen;
  int unsigned full_seen;
  int unsigned bad_index_seen;
  bit hold_off;
  bit no_send_gaps;
  bit no_recv_gaps;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #400ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [63:0] mask_of(int unsigned w);
    if (w == 0) return 64'd0;
    if (w >= 64) return '1;
    return (64'd1 << w) - 64'd1;
  endfunction

  function automatic int unsigned bits_needed(logic [63:0] v);
    int unsigned n;
    n = 0;
    for (int b = 0; b < 64; b++) if (v[b]) n = b + 1;
    return n;
  endfunction

  // entry at pos for width w, across two words when straddling
  function automatic logic [63:0] get_entry(int unsigned pos, int unsigned w);
    int unsigned bitpos;
    int unsigned wd;
    int unsigned off;
    logic [127:0] pair;
    logic [127:0] sel;
    if (w == 0) return 64'd0;
    bitpos = pos * w;
    wd = bitpos / 64;
    off = bitpos % 64;
    if (wd >= piaw_pkg::StoreWords) return 64'd0;
    pair = {(wd + 1 < piaw_pkg::StoreWords) ? shadow_words[wd + 1] : 64'd0,
            shadow_words[wd]};
    sel = (pair >> off) & {64'd0, mask_of(w)};
    return sel[63:0];
  endfunction

  task automatic put_entry(int unsigned pos, int unsigned w, logic [63:0] v);
    int unsigned bitpos;
    int unsigned wd;
    int unsigned off;
    logic [127:0] pair;
    logic [127:0] m;
    if (w == 0) return;
    bitpos = pos * w;
    wd = bitpos / 64;
    off = bitpos % 64;
    if (wd >= piaw_pkg::StoreWords) return;
    pair = {(wd + 1 < piaw_pkg::StoreWords) ? shadow_words[wd + 1] : 64'd0,
            shadow_words[wd]};
    m = {64'd0, mask_of(w)} << off;
    pair = (pair & ~m) | (({64'd0, v & mask_of(w)} << off) & m);
    shadow_words[wd] = pair[63:0];
    if (wd + 1 < piaw_pkg::StoreWords) shadow_words[wd + 1] = pair[127:64];
  endtask

  task automatic clear_shadow();
    for (int i = 0; i < piaw_pkg::StoreWords; i++) shadow_words[i] = 64'd0;
    shadow_count = 0;
    shadow_width = 0;
  endtask

  // work out the response of one request and update the shadow array
  task automatic predict_response(piaw_pkg::req_t req);
    piaw_pkg::rsp_t rsp;
    int unsigned need;
    int unsigned w;
    rsp = '0;
    rsp.status = piaw_pkg::ST_OK;
    case (piaw_pkg::cmd_e'(req.command))
      piaw_pkg::CMD_APPEND: begin
        need = bits_needed(req.value_in);
        w = (need > shadow_width) ? need : shadow_width;
        if (shadow_count >= piaw_pkg::MaxEntries ||
            (shadow_count + 1) * w > piaw_pkg::StoreBits) begin
          rsp.status = piaw_pkg::ST_FULL;
        end else begin
          if (w > shadow_width) begin
            for (int i = int'(shadow_count) - 1; i >= 0; i--)
              put_entry(unsigned'(i), w, get_entry(unsigned'(i), shadow_width));
            shadow_width = w;
          end
          put_entry(shadow_count, shadow_width, req.value_in);
          shadow_count++;
        end
      end
      piaw_pkg::CMD_READ: begin
        if (32'(req.index) >= shadow_count) rsp.status = piaw_pkg::ST_BAD_INDEX;
        else rsp.read_value = get_entry(32'(req.index), shadow_width);
      end
      piaw_pkg::CMD_CLEAR: clear_shadow();
      default: ;
    endcase
    rsp.entry_count = shadow_count[12:0];
    rsp.entry_width = shadow_width[6:0];
    expected_rsps.insert(expected_rsps.size(), rsp);
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    $display("mismatch on %s: got %0h, want %0h (response %0d)", what, got, want,
             responses_seen);
  endtask

  // send one request, gap drawn first
  task automatic send_request(piaw_pkg::cmd_e cmd, logic [63:0] val, logic [11:0] idx);
    piaw_pkg::req_t req;
    int unsigned gap;
    gap = no_send_gaps ? 0 : $urandom_range(0, 14);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req.command = cmd;
    req.value_in = val;
    req.index = idx;
    in_data_i <= req;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_response(req);
    requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    int unsigned guard;
    guard = 0;
    while (expected_rsps.size() != 0 && guard < 2000000) begin
      @(negedge clk_i);
      guard++;
    end
    if (expected_rsps.size() != 0) begin
      $display("Mismatches found");
      $finish;
    end
  endtask

  // receiver stalls
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
      stall = no_recv_gaps ? 0 : $urandom_range(0, 14);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // response checker
  initial begin
    piaw_pkg::rsp_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        responses_seen++;
        if (expected_rsps.size() == 0) begin
          report("unexpected response", out_data_o.read_value, 64'd0);
        end else begin
          want = expected_rsps.pop_front();
          if (out_data_o.read_value != want.read_value)
            report("read_value", out_data_o.read_value, want.read_value);
          if (out_data_o.entry_count != want.entry_count)
            report("entry_count", 64'(out_data_o.entry_count), 64'(want.entry_count));
          if (out_data_o.entry_width != want.entry_width)
            report("entry_width", 64'(out_data_o.entry_width), 64'(want.entry_width));
          if (out_data_o.status != want.status)
            report("status", 64'(out_data_o.status), 64'(want.status));
          if (want.status == piaw_pkg::ST_FULL) full_seen++;
          if (want.status == piaw_pkg::ST_BAD_INDEX) bad_index_seen++;
        end
      end
    end
  end

  function automatic logic [63:0] rand_value(int unsigned w);
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v & mask_of(w);
  endfunction

  // zero width, extremes, unused code, out of range reads
  task automatic test_directed();
    send_request(piaw_pkg::CMD_READ, 64'd0, 12'd0);
    send_request(piaw_pkg::CMD_APPEND, 64'd0, 12'd0);
    send_request(piaw_pkg::CMD_APPEND, 64'd0, 12'hFFF);
    send_request(piaw_pkg::CMD_READ, 64'd0, 12'd1);
    send_request(piaw_pkg::CMD_READ, 64'd0, 12'd2);
    send_request(piaw_pkg::CMD_APPEND, 64'd1, 12'd0);
    send_request(piaw_pkg::CMD_APPEND, 64'd5, 12'd0);
    send_request(piaw_pkg::CMD_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 12'd0);
    send_request(piaw_pkg::CMD_APPEND, 64'h8000_0000_0000_0000, 12'd0);
    for (int i = 0; i < 6; i++) send_request(piaw_pkg::CMD_READ, 64'd0, i[11:0]);
    send_request(piaw_pkg::CMD_READ, 64'd0, 12'hFFF);
    send_request(piaw_pkg::CMD_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 12'hFFF);
    send_request(piaw_pkg::CMD_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 12'hFFF);
    send_request(piaw_pkg::CMD_READ, 64'd0, 12'd0);
    send_request(piaw_pkg::CMD_APPEND, 64'd3, 12'd0);
    send_request(piaw_pkg::CMD_READ, 64'd0, 12'd0);
    stop_sending();
  endtask

  // many narrow entries, then one wide value walks them all across word borders
  task automatic test_widen_walk();
    send_request(piaw_pkg::CMD_CLEAR, 64'd0, 12'd0);
    for (int i = 0; i < 30; i++)
      send_request(piaw_pkg::CMD_APPEND, rand_value(3), 12'd0);
    send_request(piaw_pkg::CMD_APPEND, 64'h1_0000_0000, 12'd0);
    for (int i = 0; i < 5; i++)
      send_request(piaw_pkg::CMD_READ, 64'd0, 12'($urandom_range(0, 32)));
    stop_sending();
  endtask

  // wide values till the store is full, then more to force rejection
  task automatic test_store_full();
    send_request(piaw_pkg::CMD_CLEAR, 64'd0, 12'd0);
    send_request(piaw_pkg::CMD_APPEND, 64'h0800_0000_0000_0000, 12'd0);
    for (int i = 0; i < 70; i++)
      send_request(piaw_pkg::CMD_APPEND, rand_value(60), 12'd0);
    send_request(piaw_pkg::CMD_APPEND, 64'hFF, 12'd0);
    for (int i = 0; i < 8; i++)
      send_request(piaw_pkg::CMD_READ, 64'd0, 12'($urandom_range(0, 75)));
    send_request(piaw_pkg::CMD_CLEAR, 64'd0, 12'd0);
    for (int i = 0; i < 66; i++)
      send_request(piaw_pkg::CMD_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 12'd0);
    send_request(piaw_pkg::CMD_READ, 64'd0, 12'd63);
    send_request(piaw_pkg::CMD_READ, 64'd0, 12'd64);
    stop_sending();
  endtask

  // growing widths with random reads, block fills while receiver holds off
  task automatic test_random();
    int unsigned w;
    int unsigned pick;
    for (int phase = 0; phase < 6; phase++) begin
      no_send_gaps = (phase == 2);
      no_recv_gaps = (phase == 3);
      send_request(piaw_pkg::CMD_CLEAR, 64'd0, 12'd0);
      w = 0;
      if (phase == 1) hold_off = 1'b1;
      for (int i = 0; i < 58; i++) begin
        pick = $urandom_range(0, 19);
        if (pick < 9) begin
          if ($urandom_range(0, 9) == 0 && w < 64) w = w + $urandom_range(1, 64 - w);
          send_request(piaw_pkg::CMD_APPEND, rand_value($urandom_range(0, w)), 12'd0);
        end else if (pick < 18) begin
          send_request(piaw_pkg::CMD_READ, {$urandom, $urandom},
                       12'($urandom_range(0, shadow_count + 2)));
        end else if (pick == 18) begin
          send_request(piaw_pkg::CMD_READ, 64'd0, 12'($urandom));
        end else begin
          send_request(piaw_pkg::CMD_NONE, {$urandom, $urandom}, 12'($urandom));
        end
      end
      stop_sending();
      if (phase == 4) wait_drained();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    mismatch_count = 0;
    requests_sent = 0;
    responses_seen = 0;
    full_seen = 0;
    bad_index_seen = 0;
    hold_off = 1'b0;
    no_send_gaps = 1'b0;
    no_recv_gaps = 1'b0;
    clear_shadow();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    wait_drained();
    test_widen_walk();
    wait_drained();
    test_store_full();
    wait_drained();
    test_random();
    wait_drained();
    repeat (100) @(negedge clk_i);

    $display("covered %0d requests, %0d responses: %0d full rejections, %0d bad reads",
             requests_sent, responses_seen, full_seen, bad_index_seen);
    $display("widths from 0 to 64, zero width entries, clears and unused codes");
    if (mismatch_count == 0 && expected_rsps.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
